// File: design/lcs_pkg.sv
// Shared types, codes and constants for the compacting list store.
package lcs_pkg;

  // Storage depth default and register reset value
  localparam int unsigned DEF_MAX_ENTRIES = 256;
  localparam int unsigned CNT_W           = 9;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned WORD_W          = 32;
  localparam logic [CNT_W-1:0] CAP_RESET  = 9'd256;

  // Command codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_WRITE  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Control broadcast from the sequencer to every entry cell
  typedef struct packed {
    logic              app_en;  // append at position == cnt
    logic              rem_en;  // shift down at positions >= idx
    logic              wr_en;   // overwrite at position == idx
    logic              ld_rd;   // copy entries into the read chain
    logic              sh_rd;   // move the read chain one cell toward cell 0
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  cnt;
    logic [WORD_W-1:0] value;
  } lcs_ctl_t;

endpackage

// File: design/lcs_cell.sv
// One entry cell: holds a word and one stage of the read chain.
module lcs_cell #(
  parameter int unsigned POS_W = 8
) (
  input  logic                            clk,
  input  lcs_pkg::lcs_ctl_t               ctl,
  input  logic [POS_W-1:0]                pos,
  input  logic [lcs_pkg::WORD_W-1:0]      nxt_data,
  input  logic [lcs_pkg::WORD_W-1:0]      nxt_rd,
  output logic [lcs_pkg::WORD_W-1:0]      data,
  output logic [lcs_pkg::WORD_W-1:0]      rd
);
  import lcs_pkg::*;

  localparam int unsigned CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  logic [WORD_W-1:0] data_r, data_nxt;
  logic [WORD_W-1:0] rd_r, rd_nxt;
  logic [CMP_W-1:0]  pos_x, idx_x, cnt_x;

  assign pos_x = CMP_W'(pos);
  assign idx_x = CMP_W'(ctl.idx);
  assign cnt_x = CMP_W'(ctl.cnt);

  // Entry update: append at the tail, overwrite in place, or take the upper neighbor
  always_comb begin
    data_nxt = data_r;
    priority if (ctl.app_en && (pos_x == cnt_x)) begin
      data_nxt = ctl.value;
    end else if (ctl.wr_en && (pos_x == idx_x)) begin
      data_nxt = ctl.value;
    end else if (ctl.rem_en && (pos_x >= idx_x)) begin
      data_nxt = nxt_data;
    end
  end

  // Read chain: snapshot the entry, then pass words down toward cell 0
  always_comb begin
    rd_nxt = rd_r;
    priority if (ctl.ld_rd) begin
      rd_nxt = data_r;
    end else if (ctl.sh_rd) begin
      rd_nxt = nxt_rd;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    rd_r   <= rd_nxt;
  end

  assign data = data_r;
  assign rd   = rd_r;

endmodule

// File: design/compacting_list_store_core.sv
// Top level of the compacting list store: command sequencer and row of entry cells.
//
//  channel | ports            | direction | payload
//  --------+------------------+-----------+------------------------------------------
//  in      | in_t{valid,ready}| input     | tuser: operation; tdata: index, value
//  out     | out_t{valid,...} | output    | tuser: status; tdata: read_data, count
//  cfg     | cfg_{valid,ready}| input     | data: capacity
//
// Append, remove, write and failed commands give a registered result that
// shows on the next cycle. A successful read loads the read chain and then
// walks the word down the cell row toward cell 0, one cell a cycle.
// Reset clears the fill count and sets capacity to 256; entry contents are
// not cleared. A new item is accepted while a finished result is being taken.
module compacting_list_store_core #(
  parameter int unsigned MAX_ENTRIES = lcs_pkg::DEF_MAX_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] operation
  input  logic [39:0] in_tdata,   // [7:0] index, [39:8] value
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [47:0] out_tdata,  // [31:0] read_data, [40:32] count, rest zero
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // [8:0] capacity
);
  import lcs_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CW    = ((POS_W + 1) > CNT_W) ? (POS_W + 1) : CNT_W;

  typedef enum logic {
    S_IDLE,
    S_SHIFT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  cap_r;
  logic [IDX_W-1:0]  sh_cnt_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [WORD_W-1:0] out_rdata_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              acc;
  op_t               op;
  logic [IDX_W-1:0]  idx;
  logic [WORD_W-1:0] value;
  logic              full, range_err;
  lcs_ctl_t          ctl;

  logic [WORD_W-1:0] data_w [MAX_ENTRIES];
  logic [WORD_W-1:0] rd_w   [MAX_ENTRIES];

  // Input unpacking and checks
  assign op        = op_t'(in_tuser);
  assign idx       = in_tdata[7:0];
  assign value     = in_tdata[39:8];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign full      = (CW'(fill_r) >= CW'(cap_r)) || (CW'(fill_r) >= CW'(MAX_ENTRIES));
  assign range_err = (CW'(idx) >= CW'(fill_r)) || (CW'(idx) >= CW'(MAX_ENTRIES));

  // Broadcast to the cell row
  always_comb begin
    ctl        = '0;
    ctl.app_en = acc && (op == OP_APPEND) && !full;
    ctl.rem_en = acc && (op == OP_REMOVE) && !range_err;
    ctl.wr_en  = acc && (op == OP_WRITE) && !range_err;
    ctl.ld_rd  = acc && (op == OP_READ) && !range_err;
    ctl.sh_rd  = (state_r == S_SHIFT) && (sh_cnt_r != '0);
    ctl.idx    = idx;
    ctl.cnt    = fill_r;
    ctl.value  = value;
  end

  // Row of entry cells; the top cell feeds itself and zeros
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [WORD_W-1:0] up_data, up_rd;
    if (g == MAX_ENTRIES - 1) begin : g_top
      assign up_data = data_w[g];
      assign up_rd   = '0;
    end else begin : g_mid
      assign up_data = data_w[g+1];
      assign up_rd   = rd_w[g+1];
    end
    lcs_cell #(
      .POS_W (POS_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .pos      (POS_W'(g)),
      .nxt_data (up_data),
      .nxt_rd   (up_rd),
      .data     (data_w[g]),
      .rd       (rd_w[g])
    );
  end

  // Sequencer, fill count, capacity and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cap_r       <= CAP_RESET;
      sh_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            unique case (op)
              OP_APPEND: begin
                out_valid_r <= 1'b1;
                out_rdata_r <= '0;
                if (full) begin
                  out_status_r <= ST_FULL;
                  out_count_r  <= fill_r;
                end else begin
                  out_status_r <= ST_OK;
                  fill_r       <= fill_r + 1'b1;
                  out_count_r  <= fill_r + 1'b1;
                end
              end
              OP_REMOVE: begin
                out_valid_r <= 1'b1;
                out_rdata_r <= '0;
                if (range_err) begin
                  out_status_r <= ST_RANGE;
                  out_count_r  <= fill_r;
                end else begin
                  out_status_r <= ST_OK;
                  fill_r       <= fill_r - 1'b1;
                  out_count_r  <= fill_r - 1'b1;
                end
              end
              OP_WRITE: begin
                out_valid_r  <= 1'b1;
                out_rdata_r  <= '0;
                out_count_r  <= fill_r;
                out_status_r <= range_err ? ST_RANGE : ST_OK;
              end
              OP_READ: begin
                if (range_err) begin
                  out_valid_r  <= 1'b1;
                  out_rdata_r  <= '0;
                  out_count_r  <= fill_r;
                  out_status_r <= ST_RANGE;
                end else begin
                  // any earlier result was taken on this edge
                  out_valid_r <= 1'b0;
                  sh_cnt_r    <= idx;
                  state_r     <= S_SHIFT;
                end
              end
              default: ;
            endcase
          end else if (out_valid_r && out_tready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_SHIFT: begin
          if (sh_cnt_r == '0) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_rdata_r  <= rd_w[0];
            out_count_r  <= fill_r;
            state_r      <= S_IDLE;
          end else begin
            sh_cnt_r <= sh_cnt_r - 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_count_r, out_rdata_r};

  // Checks on the sequencer
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(fill_r) <= CW'(MAX_ENTRIES))
    else $error("fill count beyond storage depth");

  a_shift_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> !out_valid_r)
    else $error("result pending while read chain is shifting");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (op == OP_APPEND) && !full) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("append did not advance fill count");

  a_shift_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |=> $stable(fill_r))
    else $error("fill count changed during read");

endmodule

// File: verif/compacting_list_store_core_tb.sv
// Self-checking testbench for the compacting list store: command stream, result check, capacity sweeps.
`timescale 1ns / 100ps

module compacting_list_store_core_tb;
  import lcs_pkg::*;

  localparam int unsigned DEPTH       = DEF_MAX_ENTRIES;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned TAIL_CYCLES = 300;   // longest read walks the whole read chain
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      val;
  } list_cmd_t;

  typedef struct {
    status_t          st;
    logic [31:0]      rdata;
    logic [CNT_W-1:0] cnt;
  } list_resp_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // block ports
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = '0;   // [1:0] operation
  logic [39:0] in_tdata   = '0;   // [7:0] index, [39:8] value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;         // [1:0] status
  logic [47:0] out_tdata;         // [31:0] read_data, [40:32] count
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data   = '0;   // [8:0] capacity

  // list shadow used for prediction
  logic [31:0]      list_mem [DEPTH];
  logic [CNT_W-1:0] list_len = '0;
  logic [CNT_W-1:0] cap_reg  = CAP_RESET;

  // pending items and expected results
  list_cmd_t  cmd_q[$];
  list_resp_t resp_q[$];

  // generator's view of the count, used to aim indexes
  int gen_len = 0;
  int gen_cap = DEPTH;

  // idling controls, percent of cycles
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;

  // receiver hold-off
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  compacting_list_store_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // apply one command to the shadow list and return the result it gives
  function automatic list_resp_t list_step(list_cmd_t c);
    list_resp_t       r;
    logic [CNT_W-1:0] lim;
    r.st    = ST_OK;
    r.rdata = '0;
    lim     = (cap_reg > DEPTH) ? CNT_W'(DEPTH) : cap_reg;
    if (c.op == OP_APPEND) begin
      if (list_len >= lim) begin
        r.st = ST_FULL;
      end else begin
        list_mem[list_len] = c.val;
        list_len           = list_len + 1'b1;
      end
    end else if (CNT_W'(c.idx) >= list_len) begin
      r.st = ST_RANGE;
    end else if (c.op == OP_REMOVE) begin
      for (int i = c.idx; i + 1 < int'(list_len); i++) begin
        list_mem[i] = list_mem[i+1];
      end
      list_len = list_len - 1'b1;
    end else if (c.op == OP_WRITE) begin
      list_mem[c.idx] = c.val;
    end else begin
      r.rdata = list_mem[c.idx];
    end
    r.cnt = list_len;
    return r;
  endfunction

  task automatic flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  // queue one item and track the count it leads to
  task automatic push_cmd(op_t op, int idx, logic [31:0] val);
    list_cmd_t c;
    c.op  = op;
    c.idx = IDX_W'(idx);
    c.val = val;
    cmd_q.push_back(c);
    if (op == OP_APPEND) begin
      if (gen_len < gen_cap) gen_len++;
    end else if (op == OP_REMOVE && idx < gen_len) begin
      gen_len--;
    end
  endtask

  // random items; indexes mostly land inside the list
  task automatic push_random(int n, int app_pct, int rem_pct, int wr_pct);
    int   r;
    int   idx;
    op_t  op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < app_pct) op = OP_APPEND;
      else if (r < app_pct + rem_pct) op = OP_REMOVE;
      else if (r < app_pct + rem_pct + wr_pct) op = OP_WRITE;
      else op = OP_READ;
      if (gen_len > 0 && $urandom_range(0, 99) < 85) idx = $urandom_range(0, gen_len - 1);
      else idx = $urandom_range(0, 255);
      push_cmd(op, idx, $urandom);
    end
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drain();
    @(negedge clk);
    while (cmd_q.size() != 0 || in_tvalid || resp_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_capacity(int c);
    wait_drain();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= 9'(c);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gen_cap = (c > DEPTH) ? DEPTH : c;
  endtask

  // driver: present queued items, predict on acceptance
  always @(posedge clk) begin : drv
    bit took;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      took = in_tvalid && in_tready;
      if (took) resp_q.push_back(list_step(cmd_q.pop_front()));
      if (in_tvalid && !took) begin
        // hold the offered item
      end else if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= cmd_q[0].op;
        in_tdata  <= {cmd_q[0].val, cmd_q[0].idx};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : mon
    list_resp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (resp_q.size() == 0) begin
          flag_error($sformatf("result with none pending: status %0d data %h count %0d",
                               out_tuser, out_tdata[31:0], out_tdata[40:32]));
        end else begin
          want = resp_q.pop_front();
          if (out_tuser !== want.st)
            flag_error($sformatf("status got %0d want %0d", out_tuser, want.st));
          if (out_tdata[31:0] !== want.rdata)
            flag_error($sformatf("read_data got %h want %h", out_tdata[31:0], want.rdata));
          if (out_tdata[40:32] !== want.cnt)
            flag_error($sformatf("count got %0d want %0d", out_tdata[40:32], want.cnt));
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_pct);
    end
  end

  // capacity shadow follows accepted config writes
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) cap_reg <= cfg_data;
  end

  // long receiver hold-off, started on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("compacting_list_store_core regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list, extremes, every operation, shift on remove
    push_cmd(OP_READ,   0,   32'h0000_0000);
    push_cmd(OP_REMOVE, 0,   32'hFFFF_FFFF);
    push_cmd(OP_WRITE,  0,   32'hFFFF_FFFF);
    push_cmd(OP_APPEND, 255, 32'hFFFF_FFFF);  // index ignored by append
    push_cmd(OP_APPEND, 0,   32'h0000_0000);
    push_cmd(OP_APPEND, 170, 32'h8000_0000);
    push_cmd(OP_APPEND, 85,  32'h3F80_0000);
    push_cmd(OP_READ,   0,   32'hFFFF_FFFF);
    push_cmd(OP_READ,   3,   32'h0000_0000);
    push_cmd(OP_READ,   4,   32'h0000_0000);  // one past the end
    push_cmd(OP_WRITE,  1,   32'hA5A5_A5A5);
    push_cmd(OP_READ,   1,   32'h0000_0000);
    push_cmd(OP_REMOVE, 0,   32'h0000_0000);
    push_cmd(OP_READ,   0,   32'h0000_0000);
    push_cmd(OP_READ,   2,   32'h0000_0000);
    push_cmd(OP_REMOVE, 2,   32'h0000_0000);  // last entry
    push_cmd(OP_READ,   2,   32'h0000_0000);
    push_cmd(OP_REMOVE, 255, 32'h0000_0000);
    push_cmd(OP_WRITE,  255, 32'h1234_5678);
    push_cmd(OP_READ,   255, 32'h0000_0000);
    push_cmd(OP_WRITE,  0,   32'h5A5A_5A5A);
    push_cmd(OP_READ,   0,   32'h0000_0000);

    // capacity zero: every append full
    set_capacity(0);
    push_cmd(OP_APPEND, 0, 32'hDEAD_BEEF);
    push_random(40, 40, 10, 25);

    // capacity above storage: fill to the end, appends then full
    set_capacity(511);
    send_pct = 46;
    push_random(320, 85, 5, 5);

    // capacity under the count: entries kept, appends full
    set_capacity(3);
    send_pct = 0;
    recv_pct = 46;
    push_random(120, 30, 60, 5);

    // receiver holds off while the sender keeps offering
    set_capacity(300);
    recv_pct = 22;
    push_random(150, 10, 70, 10);
    @(negedge clk);
    while (!in_tvalid) @(negedge clk);
    hold_reqs++;

    // small list: drains to empty, then range errors and small fills
    set_capacity(8);
    send_pct = 22;
    recv_pct = 22;
    push_random(120, 20, 60, 10);

    // full capacity, no idling, with a pause for every result midway
    set_capacity(256);
    send_pct = 0;
    recv_pct = 0;
    push_random(75, 40, 20, 20);
    wait_drain();
    push_random(75, 40, 20, 20);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (resp_q.size() != 0) flag_error($sformatf("%0d results never came", resp_q.size()));
    if (err_cnt == 0) begin
      $display("compacting_list_store_core regression: pass");
    end else begin
      $display("compacting_list_store_core regression: fail");
    end
    $finish;
  end

endmodule

// File: compacting_list_store_core.f
design/lcs_pkg.sv
design/lcs_cell.sv
design/compacting_list_store_core.sv
verif/compacting_list_store_core_tb.sv
